FILE: src/tlfe_pkg.sv
// Shared types and constants of the tour length and fitness evaluator.
// Used by the serial arithmetic units and the top level; depends on nothing.
package tlfe_pkg;

    // Command carried in the input tuser field
    typedef enum logic
    {
        CMD_LOAD = 1'b0,
        CMD_STEP = 1'b1
    } cmd_t;

    // Status that each serial unit reports to the sequencer
    typedef struct packed
    {
        logic busy;
        logic done;
    } unit_stat_t;

    // Tour length: UQ28.8, saturating
    localparam int LEN_W      = 36;
    // Root fraction bits (radicand is scaled by two digits per fraction bit)
    localparam int ROOT_FRAC  = 8;
    // Fitness: UQ1.32 quotient of 2^40 over (length + 256)
    localparam int FIT_W      = 33;
    localparam int DIV_W      = LEN_W + 1;
    localparam int DIV_STEPS  = 41;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);
    localparam int LEN_BIAS   = 256;
    // Packed stream widths
    localparam int IDX_W      = 8;
    localparam int FIELD_W    = 16;
    localparam int NUM_W      = 16;

endpackage

FILE: src/tlfe_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; contents are undefined until written.
module tlfe_ram
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: src/tlfe_sqmul.sv
// Bit-serial sum of two squares: a*a + b*b, one multiplier bit per cycle.
// Depends on tlfe_pkg for the unit status type.
module tlfe_sqmul
    import tlfe_pkg::*;
#(
    parameter int DW = 16
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [DW-1:0]   a,
    input  logic [DW-1:0]   b,
    output logic [2*DW:0]   sum,
    output unit_stat_t      stat
);

    localparam int CNT_W = $clog2(DW + 1);

    logic [DW-1:0]    a_reg;
    logic [DW-1:0]    b_reg;
    logic [DW-1:0]    ma_reg;
    logic [DW-1:0]    mb_reg;
    logic [2*DW:0]    acc_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DW+1:0]    step_sum;

    // Add the selected multiplicands into the upper part of the product
    always_comb
    begin
        step_sum = {1'b0, acc_reg[2*DW:DW]}
                 + (ma_reg[0] ? (DW+2)'(a_reg) : '0)
                 + (mb_reg[0] ? (DW+2)'(b_reg) : '0);
    end

    // Sequence control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DW - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Shift-add datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            ma_reg  <= a;
            mb_reg  <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            ma_reg  <= ma_reg >> 1;
            mb_reg  <= mb_reg >> 1;
            acc_reg <= {step_sum, acc_reg[DW-1:1]};
        end
    end

    assign sum  = acc_reg;
    assign stat = '{busy: busy_reg, done: done_reg};

endmodule

FILE: src/tlfe_sqrt.sv
// Digit-serial integer square root of rad * 2^16, one bit pair per cycle.
// Gives the root with eight fraction bits; depends on tlfe_pkg.
module tlfe_sqrt
    import tlfe_pkg::*;
#(
    parameter int RAD_W  = 33,
    parameter int ROOT_W = (RAD_W + 2*ROOT_FRAC + 1) / 2
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [RAD_W-1:0]  rad,
    output logic [ROOT_W-1:0] root,
    output unit_stat_t        stat
);

    localparam int PAIR_W = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 2;
    localparam int CNT_W  = $clog2(ROOT_W + 1);

    logic [PAIR_W-1:0] rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  rem_sub;
    logic              ge;

    // Bring down the next pair and try the next root bit
    always_comb
    begin
        rem_sh  = {rem_reg, rad_reg[PAIR_W-1 -: 2]};
        trial   = (REM_W+2)'({root_reg, 2'b01});
        ge      = (rem_sh >= trial);
        rem_sub = rem_sh - trial;
    end

    // Sequence control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(ROOT_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Radicand shift line, remainder and root
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= PAIR_W'({rad, {(2*ROOT_FRAC){1'b0}}});
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= ge ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
            root_reg <= {root_reg[ROOT_W-2:0], ge};
        end
    end

    assign root = root_reg;
    assign stat = '{busy: busy_reg, done: done_reg};

endmodule

FILE: src/tlfe_div.sv
// Restoring serial divider for the fitness: floor(2^40 / divisor), one bit per cycle.
// Depends on tlfe_pkg for widths and the unit status type.
module tlfe_div
    import tlfe_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] divisor,
    output logic [FIT_W-1:0] quotient,
    output unit_stat_t       stat
);

    logic [DIV_W-1:0]     d_reg;
    logic [DIV_W-1:0]     rem_reg;
    logic [FIT_W-1:0]     q_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_W:0]       rem_sh;
    logic [DIV_W:0]       rem_sub;
    logic                 ge;

    // The dividend is a single one at the top bit, shifted in on the first step
    always_comb
    begin
        rem_sh  = {rem_reg, (cnt_reg == '0)};
        ge      = (rem_sh >= {1'b0, d_reg});
        rem_sub = rem_sh - {1'b0, d_reg};
    end

    // Sequence control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Remainder and quotient shift
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            d_reg   <= divisor;
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
            q_reg   <= {q_reg[FIT_W-2:0], ge};
        end
    end

    assign quotient = q_reg;
    assign stat     = '{busy: busy_reg, done: done_reg};

endmodule

FILE: src/tour_length_fitness_evaluator.sv
// Tour length and fitness evaluator: city table, serial distance path, records.
// Depends on tlfe_pkg, tlfe_ram, tlfe_sqmul, tlfe_sqrt and tlfe_div.
//
// Usage:
//   Input stream s_*: tuser[0] is the command (load city / tour step), tuser[1]
//   marks generation start, tlast marks the last city of a tour. A load writes
//   the city table and the block is ready again in the next cycle.
//   A tour step reads the city, squares the coordinate differences one bit per
//   cycle and takes the root one bit pair per cycle; the first city of a tour
//   adds no distance and only sets the start point.
//   The last city of a tour also runs the fitness divider, one quotient bit per
//   cycle, then the result goes to the output register.
//   Output stream m_*: one transfer per tour with length, fitness, tour number
//   in tdata and the record flags in tuser. The result register holds while the
//   receiver stalls and the block keeps taking input; a second result waits in
//   the sequencer until the register is free.
//   Reset clears the running length, records to all ones and the tour counter;
//   the city table is not cleared and must be loaded before it is visited.
module tour_length_fitness_evaluator
    import tlfe_pkg::*;
#(
    parameter int CITY_COUNT = 256,
    parameter int COORD_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // city_index[7:0], coord_x[23:8], coord_y[39:24]
    input  logic        s_tlast,   // tour_end
    input  logic [1:0]  s_tuser,   // command[0], generation_start[1]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // tour_length[35:0], fitness[68:36],
                                   // tour_number[84:69], zero[87:85]
    output logic [1:0]  m_tuser    // new_record[0], generation_best[1]
);

    localparam int ADDR_W = $clog2(CITY_COUNT);
    localparam int CW     = COORD_BITS;
    localparam int SQ_W   = 2 * CW + 1;
    localparam int ROOT_W = (SQ_W + 2*ROOT_FRAC + 1) / 2;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_FETCH,
        S_SQUARE,
        S_ROOT,
        S_RECORD,
        S_DIVIDE,
        S_EMIT
    } state_t;

    state_t              state_reg,     state_next;
    logic signed [CW-1:0] prev_x_reg,   prev_x_next;
    logic signed [CW-1:0] prev_y_reg,   prev_y_next;
    logic                first_reg,     first_next;
    logic [LEN_W-1:0]    len_reg,       len_next;
    logic [LEN_W-1:0]    record_reg,    record_next;
    logic [LEN_W-1:0]    gen_rec_reg,   gen_rec_next;
    logic [NUM_W-1:0]    tour_cnt_reg,  tour_cnt_next;
    logic                end_reg,       end_next;
    logic                hit_reg,       hit_next;
    logic                rec_flag_reg,  rec_flag_next;
    logic                gen_flag_reg,  gen_flag_next;
    logic                m_valid_reg,   m_valid_next;
    logic [LEN_W-1:0]    m_len_reg,     m_len_next;
    logic [FIT_W-1:0]    m_fit_reg,     m_fit_next;
    logic [NUM_W-1:0]    m_num_reg,     m_num_next;
    logic                m_rec_reg,     m_rec_next;
    logic                m_gen_reg,     m_gen_next;

    logic [IDX_W-1:0]    city_index;
    logic signed [FIELD_W-1:0] coord_x;
    logic signed [FIELD_W-1:0] coord_y;
    logic                accept;
    logic                in_range;
    logic                out_free;
    logic signed [CW-1:0] ld_x;
    logic signed [CW-1:0] ld_y;
    logic [2*CW-1:0]     rd_data;
    logic signed [CW-1:0] cur_x;
    logic signed [CW-1:0] cur_y;
    logic [CW:0]         dx_s;
    logic [CW:0]         dy_s;
    logic [CW:0]         dx_n;
    logic [CW:0]         dy_n;
    logic [CW-1:0]       dx_abs;
    logic [CW-1:0]       dy_abs;
    logic [SQ_W-1:0]     sq_sum;
    logic [ROOT_W-1:0]   root;
    logic [LEN_W:0]      len_add;
    logic [FIT_W-1:0]    quotient;
    logic                sqm_start;
    logic                sqr_start;
    logic                div_start;
    unit_stat_t          sqm_stat;
    unit_stat_t          sqr_stat;
    unit_stat_t          div_stat;

    // Unpack the input stream
    assign city_index = s_tdata[7:0];
    assign coord_x    = s_tdata[23:8];
    assign coord_y    = s_tdata[39:24];
    assign accept     = s_tvalid && s_tready;
    assign in_range   = (32'(city_index) < CITY_COUNT);
    assign ld_x       = CW'(coord_x);
    assign ld_y       = CW'(coord_y);

    // City table: y in the upper half, x in the lower half
    tlfe_ram
    #(
        .WIDTH (2 * CW),
        .DEPTH (CITY_COUNT)
    )
    u_city_ram
    (
        .clk     (clk),
        .wr_en   (accept && (s_tuser[0] == CMD_LOAD) && in_range),
        .wr_addr (ADDR_W'(city_index)),
        .wr_data ({ld_y, ld_x}),
        .rd_en   (accept && (s_tuser[0] == CMD_STEP)),
        .rd_addr (ADDR_W'(city_index)),
        .rd_data (rd_data)
    );

    // Visited city, zero outside the table, and absolute differences
    always_comb
    begin
        cur_x  = hit_reg ? rd_data[CW-1:0]    : '0;
        cur_y  = hit_reg ? rd_data[2*CW-1:CW] : '0;
        dx_s   = {cur_x[CW-1], cur_x} - {prev_x_reg[CW-1], prev_x_reg};
        dy_s   = {cur_y[CW-1], cur_y} - {prev_y_reg[CW-1], prev_y_reg};
        dx_n   = (~dx_s) + 1'b1;
        dy_n   = (~dy_s) + 1'b1;
        dx_abs = dx_s[CW] ? dx_n[CW-1:0] : dx_s[CW-1:0];
        dy_abs = dy_s[CW] ? dy_n[CW-1:0] : dy_s[CW-1:0];
    end

    assign sqm_start = (state_reg == S_FETCH) && !first_reg;
    assign sqr_start = (state_reg == S_SQUARE) && sqm_stat.done;
    assign div_start = (state_reg == S_RECORD);

    tlfe_sqmul
    #(
        .DW (CW)
    )
    u_sqmul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqm_start),
        .a     (dx_abs),
        .b     (dy_abs),
        .sum   (sq_sum),
        .stat  (sqm_stat)
    );

    tlfe_sqrt
    #(
        .RAD_W  (SQ_W),
        .ROOT_W (ROOT_W)
    )
    u_sqrt
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqr_start),
        .rad   (sq_sum),
        .root  (root),
        .stat  (sqr_stat)
    );

    tlfe_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (DIV_W'(len_reg) + DIV_W'(LEN_BIAS)),
        .quotient (quotient),
        .stat     (div_stat)
    );

    assign len_add  = {1'b0, len_reg} + (LEN_W+1)'(root);
    assign out_free = !m_valid_reg || m_tready;

    // Sequencer next state
    always_comb
    begin
        state_next    = state_reg;
        prev_x_next   = prev_x_reg;
        prev_y_next   = prev_y_reg;
        first_next    = first_reg;
        len_next      = len_reg;
        record_next   = record_reg;
        gen_rec_next  = gen_rec_reg;
        tour_cnt_next = tour_cnt_reg;
        end_next      = end_reg;
        hit_next      = hit_reg;
        rec_flag_next = rec_flag_reg;
        gen_flag_next = gen_flag_reg;
        m_valid_next  = m_valid_reg;
        m_len_next    = m_len_reg;
        m_fit_next    = m_fit_reg;
        m_num_next    = m_num_reg;
        m_rec_next    = m_rec_reg;
        m_gen_next    = m_gen_reg;

        // Drop the result once it has been transferred
        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (s_tuser[0] == CMD_STEP))
                begin
                    end_next = s_tlast;
                    hit_next = in_range;
                    if (s_tuser[1])
                    begin
                        gen_rec_next  = '1;
                        tour_cnt_next = '0;
                    end
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                prev_x_next = cur_x;
                prev_y_next = cur_y;
                if (first_reg)
                begin
                    first_next = 1'b0;
                    state_next = end_reg ? S_RECORD : S_IDLE;
                end
                else
                begin
                    state_next = S_SQUARE;
                end
            end
            S_SQUARE:
            begin
                if (sqm_stat.done)
                begin
                    state_next = S_ROOT;
                end
            end
            S_ROOT:
            begin
                if (sqr_stat.done)
                begin
                    len_next   = len_add[LEN_W] ? '1 : len_add[LEN_W-1:0];
                    state_next = end_reg ? S_RECORD : S_IDLE;
                end
            end
            S_RECORD:
            begin
                rec_flag_next = (len_reg < record_reg);
                gen_flag_next = (len_reg < gen_rec_reg);
                if (len_reg < record_reg)
                begin
                    record_next = len_reg;
                end
                if (len_reg < gen_rec_reg)
                begin
                    gen_rec_next = len_reg;
                end
                state_next = S_DIVIDE;
            end
            S_DIVIDE:
            begin
                if (div_stat.done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_len_next    = len_reg;
                    m_fit_next    = quotient;
                    m_num_next    = tour_cnt_reg;
                    m_rec_next    = rec_flag_reg;
                    m_gen_next    = gen_flag_reg;
                    tour_cnt_next = tour_cnt_reg + 1'b1;
                    len_next      = '0;
                    first_next    = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            prev_x_reg   <= '0;
            prev_y_reg   <= '0;
            first_reg    <= 1'b1;
            len_reg      <= '0;
            record_reg   <= '1;
            gen_rec_reg  <= '1;
            tour_cnt_reg <= '0;
            end_reg      <= 1'b0;
            hit_reg      <= 1'b0;
            rec_flag_reg <= 1'b0;
            gen_flag_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            m_len_reg    <= '0;
            m_fit_reg    <= '0;
            m_num_reg    <= '0;
            m_rec_reg    <= 1'b0;
            m_gen_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            prev_x_reg   <= prev_x_next;
            prev_y_reg   <= prev_y_next;
            first_reg    <= first_next;
            len_reg      <= len_next;
            record_reg   <= record_next;
            gen_rec_reg  <= gen_rec_next;
            tour_cnt_reg <= tour_cnt_next;
            end_reg      <= end_next;
            hit_reg      <= hit_next;
            rec_flag_reg <= rec_flag_next;
            gen_flag_reg <= gen_flag_next;
            m_valid_reg  <= m_valid_next;
            m_len_reg    <= m_len_next;
            m_fit_reg    <= m_fit_next;
            m_num_reg    <= m_num_next;
            m_rec_reg    <= m_rec_next;
            m_gen_reg    <= m_gen_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_num_reg, m_fit_reg, m_len_reg};
    assign m_tuser  = {m_gen_reg, m_rec_reg};

`ifndef ASSERT_OFF
    // No serial unit may still be running when a new item can enter
    a_idle_units: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (!sqm_stat.busy && !sqr_stat.busy && !div_stat.busy))
        else $error("serial unit busy while accepting input");

    // The all-time record never exceeds the generation record
    a_record_order: assert property (@(posedge clk) disable iff (!rst_n)
        record_reg <= gen_rec_reg)
        else $error("all-time record above generation record");

    // A new all-time record is always a new generation best
    a_flag_order: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> m_tuser[1])
        else $error("record flag without generation-best flag");

    // Unit completions arrive only where the sequencer waits for them
    a_sqm_done: assert property (@(posedge clk) disable iff (!rst_n)
        sqm_stat.done |-> (state_reg == S_SQUARE))
        else $error("squaring done outside its wait state");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == S_DIVIDE))
        else $error("division done outside its wait state");

    // An emitted tour leaves a cleared length and a fresh tour start
    a_tour_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && out_free) |=> (len_reg == '0 && first_reg))
        else $error("tour state not cleared after result");
`endif

endmodule

FILE: tb/tour_result_checker.sv
// Checker for the tour length and fitness evaluator: watches both stream channels,
// predicts every tour result from the accepted input transfers and compares.
// Depends on tlfe_pkg for the command codes and field widths.
`timescale 1ns / 100ps

module tour_result_checker
    import tlfe_pkg::*;
#(
    parameter int CITY_COUNT = 256,
    parameter int COORD_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,   // city_index[7:0], coord_x[23:8], coord_y[39:24]
    input  logic        s_tlast,   // tour_end
    input  logic [1:0]  s_tuser,   // command[0], generation_start[1]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [87:0] m_tdata,   // tour_length[35:0], fitness[68:36],
                                   // tour_number[84:69], zero[87:85]
    input  logic [1:0]  m_tuser,   // new_record[0], generation_best[1]
    output int          mismatches,
    output int          waiting,
    output int          compared
);

    // Saturation point of the running length
    localparam logic [63:0] LEN_SAT   = (64'd1 << LEN_W) - 64'd1;
    // Fitness numerator: 32 fraction bits over a length with ROOT_FRAC fraction bits
    localparam int          FIT_SHIFT = 32 + ROOT_FRAC;

    typedef struct packed
    {
        logic [LEN_W-1:0] length;
        logic [FIT_W-1:0] fitness;
        logic             new_rec;
        logic             gen_best;
        logic [NUM_W-1:0] number;
    } tour_result_t;

    // Own copy of the block state
    logic signed [15:0] city_x [CITY_COUNT];
    logic signed [15:0] city_y [CITY_COUNT];
    logic signed [15:0] last_x;
    logic signed [15:0] last_y;
    logic               at_tour_start;
    logic [LEN_W-1:0]   run_length;
    logic [LEN_W-1:0]   best_ever;
    logic [LEN_W-1:0]   best_in_gen;
    logic [NUM_W-1:0]   tours_in_gen;

    tour_result_t pending_tours[$];
    tour_result_t want;

    // Wrap a loaded coordinate to the table width
    function automatic logic signed [15:0] fit_coord(input logic [15:0] raw);
        logic signed [15:0] v;
        v = raw;
        return (v <<< (16 - COORD_BITS)) >>> (16 - COORD_BITS);
    endfunction

    function automatic logic [63:0] sq_span(input logic signed [15:0] a,
                                            input logic signed [15:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        if (d < 0)
            d = -d;
        return 64'(d * d);
    endfunction

    // Truncated square root with ROOT_FRAC fraction bits, built greedily bit by bit
    function automatic logic [63:0] root_q8(input logic [63:0] sq_sum);
        logic [63:0] rad;
        logic [63:0] acc;
        logic [63:0] cand;
        rad = sq_sum << (2 * ROOT_FRAC);
        acc = 64'd0;
        for (int b = 25; b >= 0; b--)
        begin
            cand = acc | (64'd1 << b);
            if (cand * cand <= rad)
                acc = cand;
        end
        return acc;
    endfunction

    // Advance the predicted state by one input transfer
    task automatic take_item(input logic [39:0] data, input logic tour_end,
                             input logic [1:0] user);
        cmd_t               cmd;
        logic [7:0]         idx;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic [63:0]        grown;
        tour_result_t       res;
        cmd = cmd_t'(user[0]);
        idx = data[7:0];
        if (cmd == CMD_LOAD)
        begin
            if (int'(idx) < CITY_COUNT)
            begin
                city_x[idx] = fit_coord(data[23:8]);
                city_y[idx] = fit_coord(data[39:24]);
            end
        end
        else
        begin
            // generation start clears the generation best before the step
            if (user[1])
            begin
                best_in_gen  = '1;
                tours_in_gen = '0;
            end
            cx = 16'sd0;
            cy = 16'sd0;
            if (int'(idx) < CITY_COUNT)
            begin
                cx = city_x[idx];
                cy = city_y[idx];
            end
            if (at_tour_start)
                at_tour_start = 1'b0;
            else
            begin
                grown = 64'(run_length) + root_q8(sq_span(cx, last_x) + sq_span(cy, last_y));
                run_length = (grown > LEN_SAT) ? LEN_SAT[LEN_W-1:0] : grown[LEN_W-1:0];
            end
            last_x = cx;
            last_y = cy;
            if (tour_end)
            begin
                res.length   = run_length;
                res.fitness  = FIT_W'((64'd1 << FIT_SHIFT) /
                                      (64'(run_length) + 64'(LEN_BIAS)));
                res.new_rec  = run_length < best_ever;
                res.gen_best = run_length < best_in_gen;
                res.number   = tours_in_gen;
                if (res.new_rec)
                    best_ever = run_length;
                if (res.gen_best)
                    best_in_gen = run_length;
                tours_in_gen  = tours_in_gen + 1'b1;
                run_length    = '0;
                at_tour_start = 1'b1;
                pending_tours = {pending_tours, res};
            end
        end
    endtask

    // Predict on input transfers, compare on output transfers
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_x        = 16'sd0;
            last_y        = 16'sd0;
            at_tour_start = 1'b1;
            run_length    = '0;
            best_ever     = '1;
            best_in_gen   = '1;
            tours_in_gen  = '0;
            pending_tours.delete();
            waiting       = 0;
            mismatches    = 0;
            compared      = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                take_item(s_tdata, s_tlast, s_tuser);
            if (m_tvalid && m_tready)
            begin
                if (pending_tours.size() == 0)
                begin
                    $error("result transfer with no tour outstanding: tdata %h tuser %b",
                           m_tdata, m_tuser);
                    mismatches++;
                end
                else
                begin
                    want = pending_tours.pop_front();
                    compared++;
                    if (m_tdata[35:0] !== want.length)
                    begin
                        $error("tour_length: expected %0d, got %0d", want.length,
                               m_tdata[35:0]);
                        mismatches++;
                    end
                    if (m_tdata[68:36] !== want.fitness)
                    begin
                        $error("fitness: expected %0d, got %0d", want.fitness,
                               m_tdata[68:36]);
                        mismatches++;
                    end
                    if (m_tuser[0] !== want.new_rec)
                    begin
                        $error("new_record: expected %0d, got %0d", want.new_rec, m_tuser[0]);
                        mismatches++;
                    end
                    if (m_tuser[1] !== want.gen_best)
                    begin
                        $error("generation_best: expected %0d, got %0d", want.gen_best,
                               m_tuser[1]);
                        mismatches++;
                    end
                    if (m_tdata[84:69] !== want.number)
                    begin
                        $error("tour_number: expected %0d, got %0d", want.number,
                               m_tdata[84:69]);
                        mismatches++;
                    end
                    if (m_tdata[87:85] !== 3'b000)
                    begin
                        $error("tdata padding: expected 0, got %0d", m_tdata[87:85]);
                        mismatches++;
                    end
                end
            end
            waiting = pending_tours.size();
        end
    end

endmodule

FILE: tb/tb.sv
// Top of the tour length and fitness evaluator testbench: clock, reset, stimulus
// and verdict. Depends on tlfe_pkg, the evaluator and tour_result_checker.
`timescale 1ns / 100ps

module tb
    import tlfe_pkg::*;
();

    // Cycles without any transfer before the run is abandoned
    localparam int QUIET_LIMIT   = 2000;
    // Tail after the last result, long enough for a step plus the divider
    localparam int TAIL_CYCLES   = 200;
    localparam int RANDOM_QUOTA  = 105;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;     // city_index[7:0], coord_x[23:8], coord_y[39:24]
    logic        s_tlast;     // tour_end
    logic [1:0]  s_tuser;     // command[0], generation_start[1]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;     // tour_length[35:0], fitness[68:36],
                              // tour_number[84:69], zero[87:85]
    logic [1:0]  m_tuser;     // new_record[0], generation_best[1]

    int mismatches;
    int waiting;
    int compared;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int items_sent    = 0;
    int tours_sent    = 0;

    bit         city_loaded [256];
    logic [7:0] loaded_cities[$];

    tour_length_fitness_evaluator DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    tour_result_checker u_tour_check
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .mismatches (mismatches),
        .waiting    (waiting),
        .compared   (compared)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Receiver stalls at the rate of the current phase
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Abandon the run when nothing transfers for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $error("no transfer for %0d cycles", QUIET_LIMIT);
        $display("FAIL tour_length_fitness_evaluator");
        $finish;
    end

    // Drive one input transfer, idling first at the sender's rate
    task automatic send_item(input cmd_t cmd, input logic [7:0] idx, input logic [15:0] x,
                             input logic [15:0] y, input logic last, input logic gstart);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {y, x, idx};
        s_tlast  <= last;
        s_tuser  <= {gstart, cmd};
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
        if (cmd == CMD_STEP && last)
            tours_sent++;
    endtask

    // Load a city; the framing bits are noise that the block ignores
    task automatic send_load(input logic [7:0] idx, input logic [15:0] x, input logic [15:0] y);
        send_item(CMD_LOAD, idx, x, y, 1'($urandom), 1'($urandom));
        if (!city_loaded[idx])
        begin
            city_loaded[idx] = 1'b1;
            loaded_cities    = {loaded_cities, idx};
        end
    endtask

    // Visit a city; the coordinate bits are unused and toggle at random
    task automatic send_step(input logic [7:0] idx, input logic last, input logic gstart);
        send_item(CMD_STEP, idx, 16'($urandom), 16'($urandom), last, gstart);
    endtask

    function automatic logic [15:0] pick_coord();
        int sel;
        sel = $urandom_range(7);
        if (sel == 0)
            return 16'h8000;
        else if (sel == 1)
            return 16'h7FFF;
        else if (sel < 4)
            return 16'($urandom_range(255)) - 16'd128;
        else
            return 16'($urandom);
    endfunction

    function automatic logic [7:0] any_city();
        return loaded_cities[$urandom_range(loaded_cities.size() - 1)];
    endfunction

    // Hold the sender off until every predicted result has arrived
    task automatic hold_until_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (waiting != 0)
            @(negedge clk);
    endtask

    // Edge cases: extreme corners, single-city and zero-length tours, framing noise
    task automatic directed_tours();
        send_load(8'd0, 16'h8000, 16'h8000);
        send_load(8'd255, 16'h7FFF, 16'h7FFF);
        send_load(8'd1, 16'd0, 16'd0);
        send_load(8'd2, 16'd3, 16'd4);
        send_load(8'd3, -16'sd5, 16'd12);
        // single city tour opening a generation
        send_step(8'd1, 1'b1, 1'b1);
        send_step(8'd1, 1'b0, 1'b0);
        send_step(8'd2, 1'b1, 1'b0);
        // corner to corner
        send_step(8'd0, 1'b0, 1'b0);
        send_step(8'd255, 1'b1, 1'b0);
        // same city repeated gives a zero length that ties the record
        send_step(8'd2, 1'b0, 1'b0);
        send_step(8'd2, 1'b0, 1'b0);
        send_step(8'd2, 1'b1, 1'b0);
        send_step(8'd1, 1'b0, 1'b0);
        send_step(8'd3, 1'b0, 1'b0);
        send_step(8'd0, 1'b0, 1'b0);
        send_step(8'd255, 1'b1, 1'b0);
        // new generation
        send_step(8'd1, 1'b0, 1'b1);
        send_step(8'd2, 1'b1, 1'b0);
        // generation start in the middle of a tour
        send_step(8'd3, 1'b0, 1'b1);
        send_step(8'd1, 1'b0, 1'b1);
        send_step(8'd2, 1'b1, 1'b0);
        // reload a city while a tour is open
        send_step(8'd2, 1'b0, 1'b0);
        send_load(8'd2, 16'd7, -16'sd24);
        send_step(8'd2, 1'b1, 1'b0);
    endtask

    // Mostly whole tours over loaded cities, with city loads and stray steps mixed in
    task automatic random_traffic(input int quota);
        int         count;
        int         pick;
        int         steps;
        logic       gen;
        logic [7:0] idx;
        count = 0;
        while (count < quota)
        begin
            pick = $urandom_range(99);
            if (pick < 12)
            begin
                idx = 8'($urandom_range(255));
                send_load(idx, pick_coord(), pick_coord());
                count++;
            end
            else if (pick < 18)
            begin
                send_step(any_city(), 1'($urandom), 1'($urandom));
                count++;
            end
            else
            begin
                steps = ($urandom_range(9) == 0) ? $urandom_range(20, 8) : $urandom_range(6, 1);
                gen   = ($urandom_range(4) == 0);
                for (int k = 0; k < steps; k++)
                    send_step(any_city(), k == steps - 1, gen && k == 0);
                count += steps;
            end
        end
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        s_tuser  = '0;
        repeat (7)
            @(negedge clk);
        rst_n = 1'b1;

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 59; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 59; end
                default: begin send_idle_pct = 18; stall_pct = 18; end
            endcase
            if (phase == 0)
            begin
                directed_tours();
                hold_until_drained();
            end
            random_traffic(RANDOM_QUOTA);
            hold_until_drained();
        end

        repeat (TAIL_CYCLES)
            @(negedge clk);

        $display("Covered %0d input transfers in %0d tours across four",
                 items_sent, tours_sent);
        $display("sender/receiver idle mixes; %0d results compared.", compared);
        if (mismatches == 0 && waiting == 0)
            $display("PASS tour_length_fitness_evaluator");
        else
        begin
            if (waiting != 0)
                $error("%0d predicted results never arrived", waiting);
            $display("FAIL tour_length_fitness_evaluator");
        end
        $finish;
    end

endmodule
